/* sv/dlp_pkg.sv */
// Package for the DDA line pixel generator.
// Holds shared widths, reset values, request codes and register indexes.
// No dependencies.
package dlp_pkg;

    // Default parameter values for the top level.
    localparam int COORD_BITS_DEF = 16;
    localparam int HEIGHT_DIV_DEF = 1024;

    // Fixed field widths.
    localparam int HGT_BITS      = 16;
    localparam int COLOR_BITS    = 32;
    localparam int DIV_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Height scaling: |max - min| * 255 fits in 24 bits.
    localparam int HEIGHT_SCALE = 255;
    localparam int PROD_BITS    = 24;
    localparam int COLOR_BIAS   = 10;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'h00FF_FFFF;

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_COLOR = 2'd2;

    // Commands from the controller to the line datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // Status from the line datapath to the controller.
    typedef struct packed {
        logic line_active;
    } t_dp_status;

endpackage

/* sv/dlp_req_if.sv */
// Request channel interface: valid/ready handshake with line endpoints.
// Depends on dlp_pkg for the default coordinate width.
interface dlp_req_if #(
    parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

/* sv/dlp_pix_if.sv */
// Pixel channel interface: valid/ready handshake with one emitted pixel.
// Depends on dlp_pkg for the default coordinate width and color width.
interface dlp_pix_if #(
    parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      pixel_x;
    logic signed [COORD_BITS-1:0]      pixel_y;
    logic [dlp_pkg::COLOR_BITS-1:0]    pixel_color;
    logic                              last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

/* sv/dda_line_pixel_generator_top.sv */
// DDA line pixel generator. A next request yields its pixel in the cycle after its
// transfer; one request is taken per cycle while the output is being drained and
// no color-step update runs. A height register write runs the color-step unit:
// input is held off through its start, three pipeline stages and return to run.
// Reset clears the line and heights and sets the color to 0x00FFFFFF.
// Depends on dlp_pkg, dlp_req_if, dlp_pix_if, dlp_ctrl, dlp_datapath, dlp_hdiv.
module dda_line_pixel_generator_top #(
    parameter int COORD_BITS     = dlp_pkg::COORD_BITS_DEF,
    parameter int HEIGHT_DIVISOR = dlp_pkg::HEIGHT_DIV_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dlp_req_if.sink                           i_req,
    dlp_pix_if.source                         o_pix,
    input  logic                              i_cfg_wr_en,
    input  logic [dlp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [dlp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import dlp_pkg::*;

    t_dp_cmd                 cmd;
    t_dp_status              status;
    logic                    div_start;
    logic                    div_busy;
    logic [COLOR_BITS-1:0]   color_step;
    logic signed [HGT_BITS-1:0] min_height;
    logic signed [HGT_BITS-1:0] max_height;
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;

    // Controller.
    dlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_req_type  (i_req.req_type),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .o_cmd       (cmd),
        .i_status    (status),
        .o_div_start (div_start),
        .i_div_busy  (div_busy)
    );

    // Line walk datapath.
    dlp_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_req.start_x),
        .i_start_y     (i_req.start_y),
        .i_end_x       (i_req.end_x),
        .i_end_y       (i_req.end_y),
        .i_color_step  (color_step),
        .o_min_height  (min_height),
        .o_max_height  (max_height),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_color (o_pix.pixel_color),
        .o_last_pixel  (o_pix.last_pixel)
    );

    // Color step unit.
    dlp_hdiv #(
        .HEIGHT_DIVISOR (HEIGHT_DIVISOR)
    ) u_hdiv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (div_start),
        .i_min_height (min_height),
        .i_max_height (max_height),
        .o_busy       (div_busy),
        .o_step       (color_step)
    );

    assign o_pix.pixel_x = $signed(pixel_x);
    assign o_pix.pixel_y = $signed(pixel_y);

endmodule

/* sv/dlp_hdiv.sv */
// Color-step unit: floor((max-min)*255 / HEIGHT_DIVISOR) - 10 by reciprocal multiplication.
// Three registered stages: quotient, remainder test, then sign and bias. Depends on dlp_pkg.
module dlp_hdiv #(
    parameter int HEIGHT_DIVISOR = dlp_pkg::HEIGHT_DIV_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [dlp_pkg::HGT_BITS-1:0] i_min_height,
    input  logic signed [dlp_pkg::HGT_BITS-1:0] i_max_height,
    output logic                                o_busy,
    output logic [dlp_pkg::COLOR_BITS-1:0]      o_step
);
    import dlp_pkg::*;

    // Reciprocal ceil(2^s / d) with s = PROD_BITS + clog2(d) gives the exact
    // quotient for every PROD_BITS-bit dividend and fits in PROD_BITS+1 bits.
    localparam int     RECIP_SHIFT = PROD_BITS + $clog2(HEIGHT_DIVISOR);
    localparam int     RECIP_BITS  = PROD_BITS + 1;
    localparam int     MUL_BITS    = PROD_BITS + RECIP_BITS;
    localparam int     BACK_BITS   = PROD_BITS + DIV_BITS;
    localparam longint RECIP_VAL   = ((longint'(1) << RECIP_SHIFT) + longint'(HEIGHT_DIVISOR) - 1)
                                   / longint'(HEIGHT_DIVISOR);
    localparam logic [RECIP_BITS-1:0] RECIP      = RECIP_BITS'(RECIP_VAL);
    localparam logic [DIV_BITS-1:0]   DIVISOR    = DIV_BITS'(HEIGHT_DIVISOR);
    localparam logic [COLOR_BITS-1:0] STEP_RESET = COLOR_BITS'(-COLOR_BIAS);

    logic [HGT_BITS:0]     diff;
    logic                  diff_neg;
    logic [HGT_BITS:0]     diff_mag;
    logic [PROD_BITS-1:0]  prod_mag;
    logic [MUL_BITS-1:0]   recip_prod;
    logic [PROD_BITS-1:0]  quo;
    logic [BACK_BITS-1:0]  back_prod;
    logic [COLOR_BITS-1:0] quo_ext;
    logic [COLOR_BITS-1:0] floor_val;

    logic [PROD_BITS-1:0]  r_prod;
    logic                  r_neg;
    logic [PROD_BITS-1:0]  r_quo;
    logic                  r_rem_nz;
    logic [2:0]            r_phase;
    logic [COLOR_BITS-1:0] r_step;

    // Magnitude of the scaled height range and its sign.
    always_comb begin
        diff     = {i_max_height[HGT_BITS-1], i_max_height}
                 - {i_min_height[HGT_BITS-1], i_min_height};
        diff_neg = diff[HGT_BITS];
        diff_mag = diff_neg ? (~diff + 1'b1) : diff;
        prod_mag = PROD_BITS'(diff_mag) * PROD_BITS'(HEIGHT_SCALE);
    end

    // Quotient of the registered magnitude by reciprocal multiplication.
    always_comb begin
        recip_prod = MUL_BITS'(r_prod) * MUL_BITS'(RECIP);
        quo        = PROD_BITS'(recip_prod >> RECIP_SHIFT);
    end

    // Multiply back for the remainder test, and floor toward minus infinity.
    always_comb begin
        back_prod = BACK_BITS'(r_quo) * BACK_BITS'(DIVISOR);
        quo_ext   = COLOR_BITS'(r_quo);
        if (r_neg) begin
            floor_val = ~(quo_ext + COLOR_BITS'(r_rem_nz)) + 1'b1;
        end else begin
            floor_val = quo_ext;
        end
    end

    // Stage sequencing and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= STEP_RESET;
        end else if (i_start) begin
            r_prod  <= prod_mag;
            r_neg   <= diff_neg;
            r_phase <= 3'b001;
        end else begin
            if (r_phase[0]) begin
                r_quo <= quo;
            end
            if (r_phase[1]) begin
                r_rem_nz <= (back_prod != BACK_BITS'(r_prod));
            end
            if (r_phase[2]) begin
                r_step <= floor_val - COLOR_BITS'(COLOR_BIAS);
            end
            r_phase <= {r_phase[1:0], 1'b0};
        end
    end

    assign o_busy = (r_phase != '0);
    assign o_step = r_step;

endmodule

/* sv/dlp_datapath.sv */
// Line datapath: endpoint registers, incremental quotient/remainder walk per axis,
// running color, height registers and the output pixel register. Depends on dlp_pkg.
module dlp_datapath #(
    parameter int COORD_BITS = dlp_pkg::COORD_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  dlp_pkg::t_dp_cmd                        i_cmd,
    output dlp_pkg::t_dp_status                     o_status,
    input  logic                                    i_cfg_wr_en,
    input  logic [dlp_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [dlp_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    input  logic [COORD_BITS-1:0]                   i_start_x,
    input  logic [COORD_BITS-1:0]                   i_start_y,
    input  logic [COORD_BITS-1:0]                   i_end_x,
    input  logic [COORD_BITS-1:0]                   i_end_y,
    input  logic [dlp_pkg::COLOR_BITS-1:0]          i_color_step,
    output logic signed [dlp_pkg::HGT_BITS-1:0]     o_min_height,
    output logic signed [dlp_pkg::HGT_BITS-1:0]     o_max_height,
    output logic [COORD_BITS-1:0]                   o_pixel_x,
    output logic [COORD_BITS-1:0]                   o_pixel_y,
    output logic [dlp_pkg::COLOR_BITS-1:0]          o_pixel_color,
    output logic                                    o_last_pixel
);
    import dlp_pkg::*;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_mag;
    logic [COORD_BITS:0]   dy_mag;
    logic [COORD_BITS-1:0] span_n;
    logic [COORD_BITS-1:0] off_x;
    logic [COORD_BITS-1:0] off_y;
    logic [COORD_BITS:0]   sum_x;
    logic [COORD_BITS:0]   sum_y;
    logic                  wrap_x;
    logic                  wrap_y;
    logic [COORD_BITS-1:0] idx_n;
    logic                  last;
    logic [COLOR_BITS-1:0] color_n;

    logic signed [HGT_BITS-1:0] r_min;
    logic signed [HGT_BITS-1:0] r_max;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_active;
    logic [COORD_BITS-1:0] r_org_x;
    logic [COORD_BITS-1:0] r_org_y;
    logic                  r_neg_x;
    logic                  r_neg_y;
    logic [COORD_BITS-1:0] r_mag_x;
    logic [COORD_BITS-1:0] r_mag_y;
    logic [COORD_BITS-1:0] r_span;
    logic [COORD_BITS-1:0] r_idx;
    logic [COORD_BITS-1:0] r_quo_x;
    logic [COORD_BITS-1:0] r_quo_y;
    logic [COORD_BITS-1:0] r_rem_x;
    logic [COORD_BITS-1:0] r_rem_y;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [COLOR_BITS-1:0] r_pcolor;
    logic                  r_last;

    // Load: deltas, their magnitudes and the span n = max(|dx|, |dy|).
    always_comb begin
        dx     = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
        dy     = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
        dx_mag = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        dy_mag = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        span_n = (dx_mag > dy_mag) ? dx_mag[COORD_BITS-1:0] : dy_mag[COORD_BITS-1:0];
    end

    // Step: pixel offset is the signed quotient; the remainder advances by |d|
    // and wraps at most once since |d| never exceeds n.
    always_comb begin
        off_x   = r_neg_x ? (~r_quo_x + 1'b1) : r_quo_x;
        off_y   = r_neg_y ? (~r_quo_y + 1'b1) : r_quo_y;
        sum_x   = {1'b0, r_rem_x} + {1'b0, r_mag_x};
        sum_y   = {1'b0, r_rem_y} + {1'b0, r_mag_y};
        wrap_x  = (sum_x >= {1'b0, r_span});
        wrap_y  = (sum_y >= {1'b0, r_span});
        idx_n   = r_idx + 1'b1;
        last    = (r_span == '0) || (idx_n == r_span);
        color_n = r_color - i_color_step;
    end

    // Control state of the line walk and the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= '0;
            r_max    <= '0;
            r_color  <= COLOR_RESET;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MIN_HEIGHT: r_min <= i_cfg_data[HGT_BITS-1:0];
                    CFG_MAX_HEIGHT: r_max <= i_cfg_data[HGT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            // A start color write reloads the running color; a step decrements it.
            if (i_cfg_wr_en && (i_cfg_index == CFG_START_COLOR)) begin
                r_color <= i_cfg_data[COLOR_BITS-1:0];
            end else if (i_cmd.step) begin
                r_color <= color_n;
            end
            if (i_cmd.load) begin
                r_active <= 1'b1;
            end else if (i_cmd.step) begin
                if (last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // Line walk registers and the output pixel register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org_x <= i_start_x;
            r_org_y <= i_start_y;
            r_neg_x <= dx[COORD_BITS];
            r_neg_y <= dy[COORD_BITS];
            r_mag_x <= dx_mag[COORD_BITS-1:0];
            r_mag_y <= dy_mag[COORD_BITS-1:0];
            r_span  <= span_n;
            r_idx   <= '0;
            r_quo_x <= '0;
            r_quo_y <= '0;
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (i_cmd.step) begin
            r_idx    <= idx_n;
            r_quo_x  <= wrap_x ? (r_quo_x + 1'b1) : r_quo_x;
            r_quo_y  <= wrap_y ? (r_quo_y + 1'b1) : r_quo_y;
            r_rem_x  <= wrap_x ? COORD_BITS'(sum_x - {1'b0, r_span}) : sum_x[COORD_BITS-1:0];
            r_rem_y  <= wrap_y ? COORD_BITS'(sum_y - {1'b0, r_span}) : sum_y[COORD_BITS-1:0];
            r_px     <= r_org_x + off_x;
            r_py     <= r_org_y + off_y;
            r_pcolor <= color_n;
            r_last   <= last;
        end
    end

    assign o_status.line_active = r_active;
    assign o_min_height  = r_min;
    assign o_max_height  = r_max;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last_pixel  = r_last;

endmodule

/* sv/dlp_ctrl.sv */
// Controller: request handshake, output valid, and sequencing of the color-step
// divider after height register writes. Depends on dlp_pkg.
module dlp_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_cfg_wr_en,
    input  logic [dlp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    output dlp_pkg::t_dp_cmd                 o_cmd,
    input  dlp_pkg::t_dp_status              i_status,
    output logic                             o_div_start,
    input  logic                             i_div_busy
);
    import dlp_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV_START,
        ST_DIV_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   height_wr;
    logic   accept;

    // Input is taken when the divider is settled and the output register frees up.
    always_comb begin
        height_wr  = i_cfg_wr_en
                   && ((i_cfg_index == CFG_MIN_HEIGHT) || (i_cfg_index == CFG_MAX_HEIGHT));
        o_in_ready = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
        accept     = i_in_valid && o_in_ready;
        o_cmd.load = accept && (i_req_type == REQ_LOAD);
        o_cmd.step = accept && (i_req_type == REQ_NEXT) && i_status.line_active;
        o_div_start = (r_state == ST_DIV_START);
    end

    // Next state and output valid.
    always_comb begin
        n_out_valid = o_cmd.step || (r_out_valid && !i_out_ready);
        n_state     = r_state;
        if (height_wr) begin
            n_state = ST_DIV_START;
        end else begin
            case (r_state)
                ST_RUN:       n_state = ST_RUN;
                ST_DIV_START: n_state = ST_DIV_WAIT;
                ST_DIV_WAIT:  n_state = i_div_busy ? ST_DIV_WAIT : ST_RUN;
                default:      n_state = ST_RUN;
            endcase
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
